// ----- rtl/pdvm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the perspective divide and viewport map block.
// Depends on nothing; the divider cell, back end and top level refer to it by scoped names.

package pdvm_pkg;

    localparam int COORD_W = 32;
    localparam int DIM_W   = 14;
    localparam int MID_W   = 35;
    localparam int WIDE_W  = 42;
    localparam int PROD_W  = 57;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic MODE_CLIP = 1'b0;
    localparam logic MODE_BACK = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd480;

    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [WIDE_W-1:0] WIDE_LIM = 42'sd1 <<< 40;

    typedef struct packed {
        logic mode;
        logic w_zero;
        logic neg_a;
        logic neg_b;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [DIM_W-1:0] w_dim;
        logic [DIM_W-1:0] h_dim;
    } side_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] val;
        logic flag;
    } sat_t;

endpackage

// ----- rtl/pdvm_div_cell.sv -----
`timescale 1ns / 1ps
// One cell of the divider chain: one restoring quotient bit for each of two lanes.
// Depends on pdvm_pkg for the sideband word that travels alongside the lanes.

module pdvm_div_cell #(
    parameter int FRAC_BITS = 16,
    localparam int NUM_W = ((2 * FRAC_BITS + 1) > 33) ? (2 * FRAC_BITS + 1) : 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   in_a_rem,
    input  logic [NUM_W-1:0]              in_a_nq,
    input  logic [31:0]                   in_a_div,
    input  logic [pdvm_pkg::DIM_W-1:0]    in_b_rem,
    input  logic [NUM_W-1:0]              in_b_nq,
    input  pdvm_pkg::side_t               in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   out_a_rem,
    output logic [NUM_W-1:0]              out_a_nq,
    output logic [31:0]                   out_a_div,
    output logic [pdvm_pkg::DIM_W-1:0]    out_b_rem,
    output logic [NUM_W-1:0]              out_b_nq,
    output pdvm_pkg::side_t               out_side
);

    logic                       valid_reg;
    logic [31:0]                a_rem_reg;
    logic [NUM_W-1:0]           a_nq_reg;
    logic [31:0]                a_div_reg;
    logic [pdvm_pkg::DIM_W-1:0] b_rem_reg;
    logic [NUM_W-1:0]           b_nq_reg;
    pdvm_pkg::side_t            side_reg;

    logic [32:0]                a_trial;
    logic [32:0]                a_diff;
    logic                       a_ge;
    logic [31:0]                a_rem_next;
    logic [NUM_W-1:0]           a_nq_next;
    logic [pdvm_pkg::DIM_W:0]   b_trial;
    logic [pdvm_pkg::DIM_W:0]   b_diff;
    logic                       b_ge;
    logic [pdvm_pkg::DIM_W-1:0] b_rem_next;
    logic [NUM_W-1:0]           b_nq_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        a_trial    = {in_a_rem, in_a_nq[NUM_W-1]};
        a_diff     = a_trial - {1'b0, in_a_div};
        a_ge       = (a_trial >= {1'b0, in_a_div});
        a_rem_next = a_ge ? a_diff[31:0] : a_trial[31:0];
        a_nq_next  = {in_a_nq[NUM_W-2:0], a_ge};

        b_trial    = {in_b_rem, in_b_nq[NUM_W-1]};
        b_diff     = b_trial - {1'b0, in_side.h_dim};
        b_ge       = (b_trial >= {1'b0, in_side.h_dim});
        b_rem_next = b_ge ? b_diff[pdvm_pkg::DIM_W-1:0] : b_trial[pdvm_pkg::DIM_W-1:0];
        b_nq_next  = {in_b_nq[NUM_W-2:0], b_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_rem_reg <= a_rem_next;
            a_nq_reg  <= a_nq_next;
            a_div_reg <= in_a_div;
            b_rem_reg <= b_rem_next;
            b_nq_reg  <= b_nq_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a_rem = a_rem_reg;
    assign out_a_nq  = a_nq_reg;
    assign out_a_div = a_div_reg;
    assign out_b_rem = b_rem_reg;
    assign out_b_nq  = b_nq_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/pdvm_post.sv -----
`timescale 1ns / 1ps
// Back end of the block: quotient sign fix-up, scaling, forward and reverse viewport mapping and clamping.
// Depends on pdvm_pkg; fed by the last cell of the divider chain.

module pdvm_post #(
    parameter int FRAC_BITS = 16,
    localparam int NUM_W = ((2 * FRAC_BITS + 1) > 33) ? (2 * FRAC_BITS + 1) : 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   a_rem,
    input  logic [NUM_W-1:0]              a_quot,
    input  logic [pdvm_pkg::DIM_W-1:0]    b_rem,
    input  logic [NUM_W-1:0]              b_quot,
    input  pdvm_pkg::side_t               side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            out_x,
    output logic signed [31:0]            out_y,
    output logic signed [31:0]            out_z,
    output logic signed [31:0]            out_w,
    output logic                          w_was_zero,
    output logic                          saturated
);

    localparam int QW  = NUM_W + 2;
    localparam int MW  = pdvm_pkg::MID_W;
    localparam int WW  = pdvm_pkg::WIDE_W;
    localparam int PW  = pdvm_pkg::PROD_W;
    localparam int DW  = pdvm_pkg::DIM_W;
    localparam logic signed [63:0] ONE_64 = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [WW-1:0] ONE_WIDE = {{(WW-1){1'b0}}, 1'b1} << FRAC_BITS;

    function automatic pdvm_pkg::sat_t sat32(input logic signed [63:0] v);
        pdvm_pkg::sat_t r;
        if (v > 64'(pdvm_pkg::Q_MAX))
        begin
            r.val  = pdvm_pkg::Q_MAX;
            r.flag = 1'b1;
        end
        else if (v < 64'(pdvm_pkg::Q_MIN))
        begin
            r.val  = pdvm_pkg::Q_MIN;
            r.flag = 1'b1;
        end
        else
        begin
            r.val  = v[31:0];
            r.flag = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [WW-1:0] clamp_wide(input logic signed [63:0] v);
        logic signed [WW-1:0] r;
        if (v > 64'(pdvm_pkg::WIDE_LIM))
        begin
            r = pdvm_pkg::WIDE_LIM;
        end
        else if (v < -64'(pdvm_pkg::WIDE_LIM))
        begin
            r = -pdvm_pkg::WIDE_LIM;
        end
        else
        begin
            r = v[WW-1:0];
        end
        return r;
    endfunction

    // Handshake of the five stages.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

    assign s5_rdy   = !s5_valid_reg || out_ready;
    assign s4_rdy   = !s4_valid_reg || s5_rdy;
    assign s3_rdy   = !s3_valid_reg || s4_rdy;
    assign s2_rdy   = !s2_valid_reg || s3_rdy;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_rdy)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_rdy)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_rdy)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage 1: floor quotients and the saturated inverse of w.
    logic signed [QW-1:0] fa, fb;
    logic signed [31:0]   inv_next;
    logic                 sat0_next;

    logic                 s1_mode_reg, s1_wz_reg, s1_sat0_reg;
    logic signed [31:0]   s1_inv_reg, s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [MW-1:0] s1_qx_reg, s1_qy_reg;
    logic [DW-1:0]        s1_wd_reg, s1_hd_reg;

    always_comb
    begin
        fa = side.neg_a ? -($signed({2'b00, a_quot}) + $signed(QW'(a_rem != '0)))
                        : $signed({2'b00, a_quot});
        fb = side.neg_b ? -($signed({2'b00, b_quot}) + $signed(QW'(b_rem != '0)))
                        : $signed({2'b00, b_quot});
        if (side.w_zero)
        begin
            inv_next  = '0;
            sat0_next = 1'b0;
        end
        else if (fa > QW'(pdvm_pkg::Q_MAX))
        begin
            inv_next  = pdvm_pkg::Q_MAX;
            sat0_next = 1'b1;
        end
        else if (fa < QW'(pdvm_pkg::Q_MIN))
        begin
            inv_next  = pdvm_pkg::Q_MIN;
            sat0_next = 1'b1;
        end
        else
        begin
            inv_next  = fa[31:0];
            sat0_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            s1_mode_reg <= side.mode;
            s1_wz_reg   <= side.w_zero;
            s1_sat0_reg <= sat0_next;
            s1_inv_reg  <= inv_next;
            s1_qx_reg   <= fa[MW-1:0];
            s1_qy_reg   <= fb[MW-1:0];
            s1_x_reg    <= side.x;
            s1_y_reg    <= side.y;
            s1_z_reg    <= side.z;
            s1_wd_reg   <= side.w_dim;
            s1_hd_reg   <= side.h_dim;
        end
    end

    // Stage 2: scale by the inverse; finish the reverse mapping.
    pdvm_pkg::sat_t      m1x_next, m1y_next, m1z_next;
    logic signed [63:0]  px_next, py_next, pz_next;

    logic                s2_mode_reg, s2_wz_reg, s2_sat0_reg, s2_m1sat_reg;
    logic signed [31:0]  s2_inv_reg, s2_m1x_reg, s2_m1y_reg, s2_m1z_reg;
    logic signed [63:0]  s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [DW-1:0]       s2_wd_reg, s2_hd_reg;

    always_comb
    begin
        px_next  = s1_x_reg * s1_inv_reg;
        py_next  = s1_y_reg * s1_inv_reg;
        pz_next  = s1_z_reg * s1_inv_reg;
        m1x_next = sat32(64'(s1_qx_reg) - ONE_64);
        m1y_next = sat32(ONE_64 - 64'(s1_qy_reg));
        m1z_next = sat32((64'(s1_z_reg) <<< 1) - ONE_64);
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_wz_reg    <= s1_wz_reg;
            s2_sat0_reg  <= s1_sat0_reg;
            s2_inv_reg   <= s1_inv_reg;
            s2_px_reg    <= px_next;
            s2_py_reg    <= py_next;
            s2_pz_reg    <= pz_next;
            s2_m1x_reg   <= m1x_next.val;
            s2_m1y_reg   <= m1y_next.val;
            s2_m1z_reg   <= m1z_next.val;
            s2_m1sat_reg <= m1x_next.flag | m1y_next.flag | m1z_next.flag;
            s2_wd_reg    <= s1_wd_reg;
            s2_hd_reg    <= s1_hd_reg;
        end
    end

    // Stage 3: device coordinates, clamped, with the viewport offsets applied.
    logic signed [WW-1:0] ax_next, by_next, cz_next;

    logic                 s3_mode_reg, s3_wz_reg, s3_sat0_reg, s3_m1sat_reg;
    logic signed [31:0]   s3_inv_reg, s3_m1x_reg, s3_m1y_reg, s3_m1z_reg;
    logic signed [WW-1:0] s3_ax_reg, s3_by_reg, s3_cz_reg;
    logic [DW-1:0]        s3_wd_reg, s3_hd_reg;

    always_comb
    begin
        ax_next = clamp_wide(s2_px_reg >>> FRAC_BITS) + ONE_WIDE;
        by_next = ONE_WIDE - clamp_wide(s2_py_reg >>> FRAC_BITS);
        cz_next = clamp_wide(s2_pz_reg >>> FRAC_BITS) + ONE_WIDE;
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_valid_reg)
        begin
            s3_mode_reg  <= s2_mode_reg;
            s3_wz_reg    <= s2_wz_reg;
            s3_sat0_reg  <= s2_sat0_reg;
            s3_inv_reg   <= s2_inv_reg;
            s3_ax_reg    <= ax_next;
            s3_by_reg    <= by_next;
            s3_cz_reg    <= cz_next;
            s3_m1x_reg   <= s2_m1x_reg;
            s3_m1y_reg   <= s2_m1y_reg;
            s3_m1z_reg   <= s2_m1z_reg;
            s3_m1sat_reg <= s2_m1sat_reg;
            s3_wd_reg    <= s2_wd_reg;
            s3_hd_reg    <= s2_hd_reg;
        end
    end

    // Stage 4: scale by the viewport size; halve and clamp the depth.
    logic signed [PW-1:0] mx_next, my_next;
    pdvm_pkg::sat_t       rz_next;

    logic                 s4_mode_reg, s4_wz_reg, s4_sat0_reg, s4_m1sat_reg, s4_satz_reg;
    logic signed [31:0]   s4_inv_reg, s4_m1x_reg, s4_m1y_reg, s4_m1z_reg, s4_rz_reg;
    logic signed [PW-1:0] s4_mx_reg, s4_my_reg;

    always_comb
    begin
        mx_next = $signed({1'b0, s3_wd_reg}) * s3_ax_reg;
        my_next = $signed({1'b0, s3_hd_reg}) * s3_by_reg;
        rz_next = sat32(64'(s3_cz_reg >>> 1));
    end

    always_ff @(posedge clk)
    begin
        if (s4_rdy && s3_valid_reg)
        begin
            s4_mode_reg  <= s3_mode_reg;
            s4_wz_reg    <= s3_wz_reg;
            s4_sat0_reg  <= s3_sat0_reg;
            s4_inv_reg   <= s3_inv_reg;
            s4_mx_reg    <= mx_next;
            s4_my_reg    <= my_next;
            s4_rz_reg    <= rz_next.val;
            s4_satz_reg  <= rz_next.flag;
            s4_m1x_reg   <= s3_m1x_reg;
            s4_m1y_reg   <= s3_m1y_reg;
            s4_m1z_reg   <= s3_m1z_reg;
            s4_m1sat_reg <= s3_m1sat_reg;
        end
    end

    // Stage 5: halve, clamp and pick the result of the selected mode.
    pdvm_pkg::sat_t     rx_next, ry_next;
    logic signed [31:0] out_x_next, out_y_next, out_z_next, out_w_next;
    logic               wz_next, sat_next;

    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg, out_w_reg;
    logic               wz_reg, sat_reg;

    always_comb
    begin
        rx_next = sat32(64'(s4_mx_reg >>> 1));
        ry_next = sat32(64'(s4_my_reg >>> 1));
        if (s4_mode_reg == pdvm_pkg::MODE_BACK)
        begin
            out_x_next = s4_m1x_reg;
            out_y_next = s4_m1y_reg;
            out_z_next = s4_m1z_reg;
            out_w_next = ONE_64[31:0];
            wz_next    = 1'b0;
            sat_next   = s4_m1sat_reg;
        end
        else
        begin
            out_x_next = rx_next.val;
            out_y_next = ry_next.val;
            out_z_next = s4_rz_reg;
            out_w_next = s4_inv_reg;
            wz_next    = s4_wz_reg;
            sat_next   = s4_sat0_reg | s4_satz_reg | rx_next.flag | ry_next.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_rdy && s4_valid_reg)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
            out_w_reg <= out_w_next;
            wz_reg    <= wz_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign out_w      = out_w_reg;
    assign w_was_zero = wz_reg;
    assign saturated  = sat_reg;

endmodule

// ----- rtl/perspective_divide_viewport_map_core.sv -----
`timescale 1ns / 1ps
// Top level of the perspective divide and viewport map block.
// Depends on pdvm_pkg, pdvm_div_cell and pdvm_post.

// One vertex word is taken every cycle unless the output backs up the pipeline, and one
// result word leaves for each, in order. The divider is a chain of NUM_W cells, NUM_W
// being the larger of 2*FRAC_BITS+1 and 33, that each resolve one quotient bit, followed
// by five stages of scaling, mapping and clamping. Every stage holds its own word, so the
// input keeps flowing while a result waits at the output until all stages are full. The
// viewport size registers should only be written while no vertex is in flight; a size of
// zero is treated as one.

module perspective_divide_viewport_map_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdvm_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic signed [31:0]                   in_x,
    input  logic signed [31:0]                   in_y,
    input  logic signed [31:0]                   in_z,
    input  logic signed [31:0]                   in_w,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   out_x,
    output logic signed [31:0]                   out_y,
    output logic signed [31:0]                   out_z,
    output logic signed [31:0]                   out_w,
    output logic                                 w_was_zero,
    output logic                                 saturated
);

    localparam int NUM_W = ((2 * FRAC_BITS + 1) > 33) ? (2 * FRAC_BITS + 1) : 33;
    localparam int DW = pdvm_pkg::DIM_W;
    localparam logic [NUM_W-1:0] NUM_ONE = {{(NUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

    logic [DW-1:0] width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pdvm_pkg::WIDTH_RESET;
            height_reg <= pdvm_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pdvm_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                pdvm_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operands of the two divider lanes.
    logic signed [32:0] two_x, two_y;
    logic [32:0]        abs_2x, abs_2y;
    logic [31:0]        abs_w;
    logic [DW-1:0]      w_dim, h_dim;
    logic [NUM_W-1:0]   a_num, b_num;
    logic [31:0]        a_div;
    pdvm_pkg::side_t    side_in;

    always_comb
    begin
        two_x  = {in_x, 1'b0};
        two_y  = {in_y, 1'b0};
        abs_2x = two_x[32] ? 33'(-two_x) : 33'(two_x);
        abs_2y = two_y[32] ? 33'(-two_y) : 33'(two_y);
        abs_w  = in_w[31] ? 32'(-in_w) : 32'(in_w);
        w_dim  = (width_reg == '0) ? DW'(1) : width_reg;
        h_dim  = (height_reg == '0) ? DW'(1) : height_reg;

        side_in.mode   = mode;
        side_in.w_zero = (mode == pdvm_pkg::MODE_CLIP) && (in_w == '0);
        side_in.x      = in_x;
        side_in.y      = in_y;
        side_in.z      = in_z;
        side_in.w_dim  = w_dim;
        side_in.h_dim  = h_dim;

        if (mode == pdvm_pkg::MODE_BACK)
        begin
            a_num          = NUM_W'(abs_2x);
            a_div          = 32'(w_dim);
            b_num          = NUM_W'(abs_2y);
            side_in.neg_a  = in_x[31];
            side_in.neg_b  = in_y[31];
        end
        else
        begin
            a_num          = NUM_ONE;
            a_div          = abs_w;
            b_num          = '0;
            side_in.neg_a  = in_w[31];
            side_in.neg_b  = 1'b0;
        end
    end

    // Divider chain.
    logic                  c_valid [0:NUM_W];
    logic                  c_ready [0:NUM_W];
    logic [31:0]           c_a_rem [0:NUM_W];
    logic [NUM_W-1:0]      c_a_nq  [0:NUM_W];
    logic [31:0]           c_a_div [0:NUM_W];
    logic [DW-1:0]         c_b_rem [0:NUM_W];
    logic [NUM_W-1:0]      c_b_nq  [0:NUM_W];
    pdvm_pkg::side_t       c_side  [0:NUM_W];

    assign c_valid[0] = in_valid;
    assign in_ready   = c_ready[0];
    assign c_a_rem[0] = '0;
    assign c_a_nq[0]  = a_num;
    assign c_a_div[0] = a_div;
    assign c_b_rem[0] = '0;
    assign c_b_nq[0]  = b_num;
    assign c_side[0]  = side_in;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_cell
        pdvm_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_a_rem  (c_a_rem[k]),
            .in_a_nq   (c_a_nq[k]),
            .in_a_div  (c_a_div[k]),
            .in_b_rem  (c_b_rem[k]),
            .in_b_nq   (c_b_nq[k]),
            .in_side   (c_side[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_a_rem (c_a_rem[k+1]),
            .out_a_nq  (c_a_nq[k+1]),
            .out_a_div (c_a_div[k+1]),
            .out_b_rem (c_b_rem[k+1]),
            .out_b_nq  (c_b_nq[k+1]),
            .out_side  (c_side[k+1])
        );
    end

    pdvm_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid[NUM_W]),
        .in_ready   (c_ready[NUM_W]),
        .a_rem      (c_a_rem[NUM_W]),
        .a_quot     (c_a_nq[NUM_W]),
        .b_rem      (c_b_rem[NUM_W]),
        .b_quot     (c_b_nq[NUM_W]),
        .side       (c_side[NUM_W]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_w      (out_w),
        .w_was_zero (w_was_zero),
        .saturated  (saturated)
    );

endmodule

// ----- rtl/pdvm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the perspective divide and viewport map block, and their binding.
// Depends on perspective_divide_viewport_map_core, to which it is bound.

module pdvm_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z,
    input logic signed [31:0] out_w,
    input logic               w_was_zero,
    input logic               saturated
);

    localparam logic [31:0] HALF = 32'd1 << (FRAC_BITS - 1);

    // A word waiting at the output stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(out_w) && $stable(w_was_zero) && $stable(saturated))
        else $error("output word changed while stalled");

    // The input only stalls when the pipeline is backed up from the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with the output free");

    // A vertex with zero w lands at the viewport centre at half depth; the check covers depth, w and flag.
    a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_was_zero |-> out_w == '0 && !saturated && out_z == HALF)
        else $error("zero w result is wrong");

endmodule

bind perspective_divide_viewport_map_core pdvm_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_pdvm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .w_was_zero (w_was_zero),
    .saturated  (saturated)
);
